[rtl/assert_macros.svh]
// Assertion macros used by the parser top level for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tomp_pkg.sv]
// Types and constants of the TCP option MSS parser.
package tomp_pkg;

   localparam logic [15:0] LOCAL_MSS_RESET = 16'd1460;

   localparam logic [7:0] KIND_END  = 8'd0;
   localparam logic [7:0] KIND_NOP  = 8'd1;
   localparam logic [7:0] KIND_MSS  = 8'd2;
   localparam logic [7:0] LEN_MIN   = 8'd2;
   localparam logic [7:0] LEN_MSS_V = 8'd4;

   typedef enum logic [2:0] {
      PH_KIND    = 3'd0,
      PH_LEN_GEN = 3'd1,
      PH_LEN_MSS = 3'd2,
      PH_MSS_HI  = 3'd3,
      PH_MSS_LO  = 3'd4,
      PH_SKIP    = 3'd5,
      PH_STOP    = 3'd6
   } parse_phase_type;

   typedef struct packed {
      parse_phase_type phase;
      logic [7:0]      skip_left;
      logic [15:0]     running_mss;
      logic [7:0]      mss_high_byte;
      logic            bad_seen;
   } parse_state_type;

   typedef struct packed {
      logic [15:0] negotiated_mss;
      logic        malformed;
   } parse_result_type;

endpackage

[rtl/tcp_option_mss_parser.sv]
// Top level of the TCP option MSS parser: input stage, walker state, result register.
//
// Usage:
//   req_*  : option bytes of one TCP header, one item per byte; req_area_last
//            marks the final byte of the option area. Taken when req_valid is
//            high and req_stall is low.
//   rsp_*  : one item per option area, carrying the negotiated MSS (minimum of
//            local MSS and every MSS option value) and a malformed flag (bad
//            length, or an option cut off by the end of the area).
//   csr_*  : csr_wr_en writes csr_wr_data into the local MSS and reloads the
//            running MSS; write only while the parser is idle.
// Timing: a byte is held in the input register and is folded into the walker
//   state when it leaves it; the result of a last byte goes from the input
//   register into the result register. One byte per cycle while req_stall is low;
//   the walker update is a single pass of short logic between the two registers.
// Reset: synchronous, active high; local MSS returns to 1460, walker expects
//   a kind byte, both valids clear.
// Stall: the result register holds while rsp_stall is high. Non-last bytes
//   keep flowing; req_stall rises only when a last byte waits in the input
//   register behind a result that has not been taken.
module tcp_option_mss_parser import tomp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opt_byte,
   input  logic        req_area_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_negotiated_mss,
   output logic        rsp_malformed,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

`include "assert_macros.svh"

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // walker state and configuration
   parse_state_type parse_ff, parse_in, parse_step;
   logic [15:0]     local_mss_ff, local_mss_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   parse_result_type rsp_data_ff, step_result;

   logic req_take;
   logic s1_adv;
   logic rsp_load;

   // a non-last byte never needs the result register
   assign s1_adv    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = s1_adv && s1_last_ff;

   tomp_parse_step u_step (
      .cur_state  (parse_ff),
      .opt_byte   (s1_byte_ff),
      .area_last  (s1_last_ff),
      .local_mss  (local_mss_ff),
      .next_state (parse_step),
      .result     (step_result)
   );

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      local_mss_in = csr_wr_en ? csr_wr_data : local_mss_ff;
      parse_in     = s1_adv ? parse_step : parse_ff;
      if (csr_wr_en) begin
         parse_in.running_mss = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         local_mss_ff           <= LOCAL_MSS_RESET;
         parse_ff.phase         <= PH_KIND;
         parse_ff.skip_left     <= 8'd0;
         parse_ff.running_mss   <= LOCAL_MSS_RESET;
         parse_ff.mss_high_byte <= 8'd0;
         parse_ff.bad_seen      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         local_mss_ff <= local_mss_in;
         parse_ff     <= parse_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_opt_byte;
         s1_last_ff <= req_area_last;
      end
      if (rsp_load) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_negotiated_mss = rsp_data_ff.negotiated_mss;
   assign rsp_malformed      = rsp_data_ff.malformed;

   // checks
   `ASSERT_CLK(a_rsp_from_last, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff), "result without a last byte")
   `ASSERT_CLK(a_restart_after_last, clock, reset,
      (rsp_load && !csr_wr_en) |=> (parse_ff.phase == PH_KIND && parse_ff.skip_left == 8'd0
      && !parse_ff.bad_seen), "walker not restarted after area end")
   `ASSERT_CLK(a_stall_cause, clock, reset,
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall),
      "input stalled without a blocked result")

endmodule

[rtl/tomp_parse_step.sv]
// Per-byte next-state logic of the option walker, with end-of-area restart.
module tomp_parse_step import tomp_pkg::*; (
   input  parse_state_type  cur_state,
   input  logic [7:0]       opt_byte,
   input  logic             area_last,
   input  logic [15:0]      local_mss,
   output parse_state_type  next_state,
   output parse_result_type result
);

   always_comb begin
      parse_state_type st;
      logic [15:0]     mss_val;
      st      = cur_state;
      mss_val = {cur_state.mss_high_byte, opt_byte};

      case (cur_state.phase)
         PH_KIND: begin
            if (opt_byte == KIND_END) begin
               st.phase = PH_STOP;
            end else if (opt_byte == KIND_NOP) begin
               st.phase = PH_KIND;
            end else if (opt_byte == KIND_MSS) begin
               st.phase = PH_LEN_MSS;
            end else begin
               st.phase = PH_LEN_GEN;
            end
         end
         PH_LEN_GEN, PH_LEN_MSS: begin
            if (opt_byte < LEN_MIN) begin
               st.bad_seen = 1'b1;
               st.phase    = PH_STOP;
            end else if (cur_state.phase == PH_LEN_MSS && opt_byte >= LEN_MSS_V) begin
               st.skip_left = opt_byte - LEN_MSS_V;
               st.phase     = PH_MSS_HI;
            end else begin
               st.skip_left = opt_byte - LEN_MIN;
               st.phase     = (st.skip_left == 8'd0) ? PH_KIND : PH_SKIP;
            end
         end
         PH_MSS_HI: begin
            st.mss_high_byte = opt_byte;
            st.phase         = PH_MSS_LO;
         end
         PH_MSS_LO: begin
            if (mss_val < cur_state.running_mss) begin
               st.running_mss = mss_val;
            end
            st.phase = (cur_state.skip_left == 8'd0) ? PH_KIND : PH_SKIP;
         end
         PH_SKIP: begin
            if (cur_state.skip_left != 8'd0) begin
               st.skip_left = cur_state.skip_left - 8'd1;
            end
            st.phase = (st.skip_left == 8'd0) ? PH_KIND : PH_SKIP;
         end
         default: begin
            st.phase = PH_STOP;
         end
      endcase

      // option still open at the end of the area
      if (area_last && st.phase != PH_KIND && st.phase != PH_STOP) begin
         st.bad_seen = 1'b1;
      end

      result.negotiated_mss = st.running_mss;
      result.malformed      = st.bad_seen;

      if (area_last) begin
         next_state.phase         = PH_KIND;
         next_state.skip_left     = 8'd0;
         next_state.running_mss   = local_mss;
         next_state.mss_high_byte = 8'd0;
         next_state.bad_seen      = 1'b0;
      end else begin
         next_state = st;
      end
   end

endmodule
